// ===== hdl/separable_sliding_minimum_2d_macros.svh =====
// Assertion helpers used by the top-level RTL of the sliding minimum filter.
`ifndef SEPARABLE_SLIDING_MINIMUM_2D_MACROS_SVH
`define SEPARABLE_SLIDING_MINIMUM_2D_MACROS_SVH

// Same-cycle implication, checked only out of reset.
`define SSM2D_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only out of reset.
`define SSM2D_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ssm2d_pkg.sv =====
package ssm2d_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int RING_ROWS  = 66;
    localparam int HALF_MAX   = 32;
    localparam int PIX_W      = 32;
    localparam int COL_W      = 12;
    localparam int ROW_W      = 13;
    localparam int RING_W     = 7;
    localparam int HALF_W     = 6;
    localparam int CNT_W      = 7;
    localparam int CFG_W      = 13;
    localparam int WIN_W      = 7;
    localparam int RING_AW    = RING_W + COL_W;

    localparam logic [CFG_W-1:0] RST_WIDTH  = 13'd1024;
    localparam logic [CFG_W-1:0] RST_HEIGHT = 13'd1024;
    localparam logic [WIN_W-1:0] RST_WINDOW = 7'd8;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_WINDOW = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HSET,
        ST_SCAN,
        ST_LAST,
        ST_VCHK,
        ST_EMIT
    } state_t;

    // Control of the shared minimum unit.
    typedef struct packed {
        logic start;
        logic take;
    } min_ctl_t;

endpackage

// ===== hdl/ssm2d_min_unit.sv =====
module ssm2d_min_unit
    import ssm2d_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  min_ctl_t                ctl,
    input  logic signed [PIX_W-1:0] sample,
    output logic signed [PIX_W-1:0] result
);

    logic signed [PIX_W-1:0] acc_reg;
    logic                    first_reg;

    // Shared signed comparator; the first sample of a run seeds the minimum.
    assign result = first_reg ? sample : ((sample < acc_reg) ? sample : acc_reg);

    always_ff @(posedge aclk) begin
        if (ctl.take) begin
            acc_reg <= result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg <= 1'b1;
        end else if (ctl.start) begin
            first_reg <= 1'b1;
        end else if (ctl.take) begin
            first_reg <= 1'b0;
        end
    end

endmodule

// ===== hdl/separable_sliding_minimum_2d.sv =====
// A request that forms no row minimum and yields no result goes from ST_IDLE through
// ST_VCHK back to ST_IDLE. Each row minimum passes ST_HSET, ST_SCAN and ST_LAST; a result
// follows its vertical pass and waits in ST_EMIT while the output slot is full and m_tready is low.
// One request at a time; a row end forms up to hx row minima one after another, as there
// is a single shared comparator and one read port per buffer.
// Reset (aresetn low, synchronous) restores default registers and clears positions.
`include "separable_sliding_minimum_2d_macros.svh"

module separable_sliding_minimum_2d
    import ssm2d_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [PIX_W-1:0]   s_tdata,   // [31:0] pixel_value
    input  logic               s_tuser,   // [0] op
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [PIX_W-1:0]   m_tdata,   // [31:0] min_value
    output logic               m_tlast,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_addr,
    input  logic [CFG_W-1:0]   cfg_wdata
);

    state_t state_reg, state_next;

    logic [CFG_W-1:0]  width_reg, height_reg;
    logic [WIN_W-1:0]  win_reg;
    logic [COL_W-1:0]  in_col_reg, in_col_next, out_col_reg, out_col_next;
    logic [ROW_W-1:0]  in_row_reg, in_row_next, out_row_reg, out_row_next;
    logic [RING_W-1:0] in_ring_reg, in_ring_next, out_ring_reg, out_ring_next;
    logic [RING_W-1:0] wr_ring_reg, wr_ring_next, ring_pos_reg, ring_pos_next;
    logic [COL_W-1:0]  x_reg, x_next, x_end_reg, x_end_next, pos_reg, pos_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              vpass_reg, vpass_next, rd_vld_reg;
    logic signed [PIX_W-1:0] res_reg, res_next;
    logic              res_last_reg, res_last_next;
    logic              m_tvalid_reg, m_tvalid_next, m_tlast_reg;
    logic [PIX_W-1:0]  m_tdata_reg;

    logic signed [PIX_W-1:0] raw_mem [MAX_WIDTH];
    logic signed [PIX_W-1:0] ring_mem [RING_ROWS*MAX_WIDTH];
    logic signed [PIX_W-1:0] raw_rdata_reg, ring_rdata_reg, min_in, min_out;
    logic [RING_AW-1:0] ring_raddr, ring_waddr;
    logic              raw_we, ring_we, in_acc, pix_acc, clear_pos, slot_free;
    min_ctl_t          min_ctl;

    logic [CFG_W-1:0]  eff_w, eff_h;
    logic [HALF_W-1:0] h_raw, half, hx, hy, k_top;
    logic [CFG_W:0]    c_plus, x_sum, oc_sum, bot_sum;
    logic [CFG_W-1:0]  lo, hi, top, bot, rr, oc_hi;
    logic [RING_W:0]   top_ring_ext;
    logic              ready, is_last;

    // Effective sizes with the clamping rules applied.
    assign h_raw = win_reg[WIN_W-1:1];
    always_comb begin
        eff_w = (width_reg == '0) ? CFG_W'(1)
              : ((width_reg > CFG_W'(MAX_WIDTH)) ? CFG_W'(MAX_WIDTH) : width_reg);
        eff_h = (height_reg == '0) ? CFG_W'(1)
              : ((height_reg > CFG_W'(MAX_HEIGHT)) ? CFG_W'(MAX_HEIGHT) : height_reg);
        half  = (h_raw == '0) ? HALF_W'(1)
              : ((h_raw > HALF_W'(HALF_MAX)) ? HALF_W'(HALF_MAX) : h_raw);
        hx    = (CFG_W'(half) < eff_w) ? half : eff_w[HALF_W-1:0];
        hy    = (CFG_W'(half) < eff_h) ? half : eff_h[HALF_W-1:0];
    end

    // Horizontal window of the row minimum being formed.
    always_comb begin
        x_sum = (CFG_W+1)'(x_reg) + (CFG_W+1)'(hx);
        lo    = (x_reg >= COL_W'(hx)) ? CFG_W'(x_reg - COL_W'(hx)) : '0;
        hi    = (x_sum <= (CFG_W+1)'(eff_w)) ? x_sum[CFG_W-1:0] : eff_w;
    end

    // Vertical window and readiness of the next result pixel.
    always_comb begin
        k_top   = (out_row_reg >= ROW_W'(hy)) ? hy : out_row_reg[HALF_W-1:0];
        top     = out_row_reg - ROW_W'(k_top);
        bot_sum = (CFG_W+1)'(out_row_reg) + (CFG_W+1)'(hy);
        bot     = (bot_sum <= (CFG_W+1)'(eff_h)) ? bot_sum[CFG_W-1:0] : eff_h;
        rr      = bot - CFG_W'(1);
        oc_sum  = (CFG_W+1)'(out_col_reg) + (CFG_W+1)'(hx);
        oc_hi   = ((oc_sum <= (CFG_W+1)'(eff_w)) ? oc_sum[CFG_W-1:0] : eff_w) - CFG_W'(1);
        ready   = (rr < in_row_reg)
               || ((rr == in_row_reg) && (oc_hi < CFG_W'(in_col_reg)));
        top_ring_ext = (out_ring_reg >= RING_W'(k_top))
                     ? (RING_W+1)'(out_ring_reg - RING_W'(k_top))
                     : (RING_W+1)'(out_ring_reg) + (RING_W+1)'(RING_ROWS)
                       - (RING_W+1)'(k_top);
        is_last = (out_row_reg + ROW_W'(1) == eff_h)
               && (CFG_W'(out_col_reg) + CFG_W'(1) == eff_w);
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign pix_acc   = in_acc && !s_tuser && (in_row_reg < eff_h)
                     && (CFG_W'(in_col_reg) < eff_w);
    assign c_plus    = (CFG_W+1)'(in_col_reg) + (CFG_W+1)'(1);
    assign slot_free = !m_tvalid_reg || m_tready;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    if (pix_acc && ((c_plus == (CFG_W+1)'(eff_w))
                                    || (c_plus >= (CFG_W+1)'(hx)))) begin
                        state_next = ST_HSET;
                    end else begin
                        state_next = ST_VCHK;
                    end
                end
            end
            ST_HSET: state_next = ST_SCAN;
            ST_SCAN: begin
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST: begin
                if (vpass_reg) begin
                    state_next = ST_EMIT;
                end else if (x_reg == x_end_reg) begin
                    state_next = ST_VCHK;
                end else begin
                    state_next = ST_HSET;
                end
            end
            ST_VCHK: begin
                if ((out_row_reg >= eff_h) || (CFG_W'(out_col_reg) >= eff_w) || !ready) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and counter updates.
    always_comb begin
        in_col_next   = in_col_reg;
        in_row_next   = in_row_reg;
        in_ring_next  = in_ring_reg;
        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        out_ring_next = out_ring_reg;
        wr_ring_next  = wr_ring_reg;
        ring_pos_next = ring_pos_reg;
        x_next        = x_reg;
        x_end_next    = x_end_reg;
        pos_next      = pos_reg;
        cnt_next      = cnt_reg;
        vpass_next    = vpass_reg;
        res_next      = res_reg;
        res_last_next = res_last_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        raw_we        = 1'b0;
        ring_we       = 1'b0;
        clear_pos     = 1'b0;
        min_ctl       = '0;
        case (state_reg)
            ST_IDLE: begin
                if (pix_acc) begin
                    raw_we       = 1'b1;
                    wr_ring_next = in_ring_reg;
                    if (c_plus == (CFG_W+1)'(eff_w)) begin
                        x_next     = COL_W'(eff_w - CFG_W'(hx));
                        x_end_next = COL_W'(eff_w - CFG_W'(1));
                    end else begin
                        x_next     = COL_W'(c_plus - (CFG_W+1)'(hx));
                        x_end_next = COL_W'(c_plus - (CFG_W+1)'(hx));
                    end
                    if (c_plus >= (CFG_W+1)'(eff_w)) begin
                        in_col_next  = '0;
                        in_row_next  = in_row_reg + ROW_W'(1);
                        in_ring_next = (in_ring_reg == RING_W'(RING_ROWS - 1))
                                     ? '0 : in_ring_reg + RING_W'(1);
                    end else begin
                        in_col_next = in_col_reg + COL_W'(1);
                    end
                end
            end
            ST_HSET: begin
                pos_next      = COL_W'(lo);
                cnt_next      = CNT_W'(hi - lo);
                vpass_next    = 1'b0;
                min_ctl.start = 1'b1;
            end
            ST_SCAN: begin
                min_ctl.take  = rd_vld_reg;
                cnt_next      = cnt_reg - CNT_W'(1);
                pos_next      = pos_reg + COL_W'(1);
                ring_pos_next = (ring_pos_reg == RING_W'(RING_ROWS - 1))
                              ? '0 : ring_pos_reg + RING_W'(1);
            end
            ST_LAST: begin
                if (vpass_reg) begin
                    res_next      = min_out;
                    res_last_next = is_last;
                end else begin
                    ring_we = 1'b1;
                    x_next  = x_reg + COL_W'(1);
                end
            end
            ST_VCHK: begin
                if ((out_row_reg >= eff_h) || (CFG_W'(out_col_reg) >= eff_w)) begin
                    clear_pos = 1'b1;
                end
                ring_pos_next = top_ring_ext[RING_W-1:0];
                cnt_next      = CNT_W'(bot - top);
                vpass_next    = 1'b1;
                min_ctl.start = 1'b1;
            end
            ST_EMIT: begin
                if (slot_free) begin
                    m_tvalid_next = 1'b1;
                    if (res_last_reg) begin
                        clear_pos = 1'b1;
                    end else if (CFG_W'(out_col_reg) + CFG_W'(1) >= eff_w) begin
                        out_col_next  = '0;
                        out_row_next  = out_row_reg + ROW_W'(1);
                        out_ring_next = (out_ring_reg == RING_W'(RING_ROWS - 1))
                                      ? '0 : out_ring_reg + RING_W'(1);
                    end else begin
                        out_col_next = out_col_reg + COL_W'(1);
                    end
                end
            end
            default: begin
                clear_pos = 1'b1;
            end
        endcase
        // A write to one of the three registers restarts the frame.
        if (clear_pos
            || (cfg_we && (cfg_addr inside {CFG_WIDTH, CFG_HEIGHT, CFG_WINDOW}))) begin
            in_col_next   = '0;
            in_row_next   = '0;
            in_ring_next  = '0;
            out_col_next  = '0;
            out_row_next  = '0;
            out_ring_next = '0;
        end
    end

    // Shared minimum unit.
    assign min_in = vpass_reg ? ring_rdata_reg : raw_rdata_reg;

    ssm2d_min_unit u_min (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (min_ctl),
        .sample  (min_in),
        .result  (min_out)
    );

    // Raw row buffer.
    always_ff @(posedge aclk) begin
        if (raw_we) begin
            raw_mem[in_col_reg] <= $signed(s_tdata);
        end
        raw_rdata_reg <= raw_mem[pos_reg];
    end

    // Ring of row minima, addressed by ring row and column.
    assign ring_raddr = {ring_pos_reg, out_col_reg};
    assign ring_waddr = {wr_ring_reg, x_reg};
    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring_mem[ring_waddr] <= min_out;
        end
        ring_rdata_reg <= ring_mem[ring_raddr];
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        wr_ring_reg  <= wr_ring_next;
        ring_pos_reg <= ring_pos_next;
        x_reg        <= x_next;
        x_end_reg    <= x_end_next;
        pos_reg      <= pos_next;
        cnt_reg      <= cnt_next;
        res_reg      <= res_next;
        res_last_reg <= res_last_next;
        if ((state_reg == ST_EMIT) && slot_free) begin
            m_tdata_reg <= res_reg;
            m_tlast_reg <= res_last_reg;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            width_reg    <= RST_WIDTH;
            height_reg   <= RST_HEIGHT;
            win_reg      <= RST_WINDOW;
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_ring_reg  <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_ring_reg <= '0;
            vpass_reg    <= 1'b0;
            rd_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            in_ring_reg  <= in_ring_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            out_ring_reg <= out_ring_next;
            vpass_reg    <= vpass_next;
            rd_vld_reg   <= (state_reg == ST_SCAN);
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_WIDTH:  width_reg  <= cfg_wdata;
                    CFG_HEIGHT: height_reg <= cfg_wdata;
                    CFG_WINDOW: win_reg    <= cfg_wdata[WIN_W-1:0];
                    default:    ;
                endcase
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    `SSM2D_ASSERT_NOW(a_scan_cnt, state_reg == ST_SCAN, cnt_reg != '0, "scan with empty count")
    `SSM2D_ASSERT_NOW(a_last_data, state_reg == ST_LAST, rd_vld_reg, "last step without data")
    `SSM2D_ASSERT_NEXT(a_emit_load, (state_reg == ST_EMIT) && slot_free, m_tvalid_reg && (state_reg == ST_IDLE), "result not loaded")
    `SSM2D_ASSERT_NOW(a_col_range, !cfg_we && (state_reg == ST_IDLE), CFG_W'(in_col_reg) < eff_w, "input column out of range")

endmodule

// ===== dv/separable_sliding_minimum_2d_tb.sv =====
`timescale 1ns / 1ps

module separable_sliding_minimum_2d_tb;
    import ssm2d_pkg::*;

    localparam logic       OP_PIXEL  = 1'b0;
    localparam logic       OP_FLUSH  = 1'b1;
    localparam logic [1:0] CFG_SPARE = 2'd3;   // unused register index
    localparam int         SETTLE    = 2500;   // worst row end plus vertical pass
    localparam int         STALL_MAX = 50000;
    localparam int         N_ITEMS   = 850;
    localparam int         N_DIR     = 25;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    // One line of the directed table; want_cnt of -1 leaves the check to the predictor.
    typedef struct {
        row_kind_t   kind;
        logic [1:0]  addr;
        logic [31:0] data;
        logic        op;
        int          want_cnt;
        logic [31:0] want_val;
        logic        want_last;
    } dir_row_t;

    typedef struct {
        logic [31:0] val;
        logic        last;
    } minimum_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [PIX_W-1:0]   s_tdata = '0;
    logic               s_tuser = 1'b0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [PIX_W-1:0]   m_tdata;
    logic               m_tlast;
    logic               cfg_we = 1'b0;
    logic [1:0]         cfg_addr = '0;
    logic [CFG_W-1:0]   cfg_wdata = '0;

    separable_sliding_minimum_2d i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Mirror of the filter state.
    logic [12:0]        width_reg;
    logic [12:0]        height_reg;
    logic [6:0]         window_reg;
    logic signed [31:0] row_pixels [MAX_WIDTH];
    logic signed [31:0] row_minima [RING_ROWS][MAX_WIDTH];
    int unsigned        in_col, in_row, out_col, out_row;

    minimum_t pending_minima[$];
    int       mismatches = 0;
    int       failures = 0;
    int       stall_cycles = 0;
    int       items_sent = 0;
    bit       no_idle = 1'b0;

    function automatic int unsigned clamp_u(int unsigned v, int unsigned lo, int unsigned hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic int unsigned span_lo(int unsigned p, int unsigned h);
        return (p >= h) ? p - h : 0;
    endfunction

    function automatic int unsigned span_hi(int unsigned p, int unsigned h, int unsigned n);
        return (p + h <= n) ? p + h : n;
    endfunction

    function automatic void clear_positions();
        in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    endfunction

    function automatic bit frame_open();
        return (in_col | in_row | out_col | out_row) != 0;
    endfunction

    function automatic void reset_filter_model();
        width_reg = RST_WIDTH;
        height_reg = RST_HEIGHT;
        window_reg = RST_WINDOW;
        foreach (row_pixels[i]) row_pixels[i] = '0;
        foreach (row_minima[r, c]) row_minima[r][c] = '0;
        clear_positions();
    endfunction

    // Horizontal minimum of column x of the current row.
    function automatic void form_row_minimum(int unsigned x, int unsigned hx, int unsigned w);
        int unsigned        l;
        int unsigned        r;
        logic signed [31:0] m;
        l = span_lo(x, hx);
        r = span_hi(x, hx, w);
        m = row_pixels[l];
        for (int unsigned i = l + 1; i < r; i++)
            if (row_pixels[i] < m) m = row_pixels[i];
        row_minima[in_row % RING_ROWS][x] = m;
    endfunction

    // Advances the mirror by one request; returns 1 when a minimum comes out.
    function automatic bit predict_minimum(logic op, logic [31:0] pix, output minimum_t res);
        int unsigned        w, hg, h, hx, hy, top, bot;
        logic signed [31:0] m;
        bit                 ready;
        res = '{val: '0, last: 1'b0};
        w  = clamp_u(width_reg, 1, MAX_WIDTH);
        hg = clamp_u(height_reg, 1, MAX_HEIGHT);
        h  = clamp_u(window_reg / 2, 1, HALF_MAX);
        hx = (h < w) ? h : w;
        hy = (h < hg) ? h : hg;
        if (hy > (RING_ROWS - 1) / 2) hy = (RING_ROWS - 1) / 2;

        if (op == OP_PIXEL && in_row < hg && in_col < w) begin
            row_pixels[in_col] = pix;
            if (in_col + 1 == w) begin
                for (int unsigned i = (w > hx) ? w - hx : 0; i < w; i++)
                    form_row_minimum(i, hx, w);
            end else if (in_col + 1 >= hx) begin
                form_row_minimum(in_col + 1 - hx, hx, w);
            end
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
            end
        end

        if (out_row >= hg || out_col >= w) begin
            clear_positions();
            return 1'b0;
        end

        // Vertical pass once every row minimum of the window is in.
        top = span_lo(out_row, hy);
        bot = span_hi(out_row, hy, hg);
        ready = (bot - 1 < in_row) ||
                (bot - 1 == in_row && span_hi(out_col, hx, w) - 1 < in_col);
        if (!ready) return 1'b0;
        m = row_minima[top % RING_ROWS][out_col];
        for (int unsigned i = top + 1; i < bot; i++)
            if (row_minima[i % RING_ROWS][out_col] < m) m = row_minima[i % RING_ROWS][out_col];
        res.val = m;
        res.last = (out_row + 1 == hg) && (out_col + 1 == w);
        if (res.last) begin
            clear_positions();
        end else begin
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
            end
        end
        return 1'b1;
    endfunction

    // Hands one request to the filter and updates the mirror when it is taken.
    task automatic send_request(logic op, logic [31:0] pix, output bit got, output minimum_t res);
        if (!no_idle && $urandom_range(99) < 31) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= pix;
        do @(posedge aclk); while (!s_tready);
        got = predict_minimum(op, pix, res);
        if (got) pending_minima = {pending_minima, res};
        items_sent++;
    endtask

    task automatic send_item(logic op, logic [31:0] pix);
        bit       got;
        minimum_t res;
        send_request(op, pix, got, res);
    endtask

    // Waits for every minimum to come out and for the filter to settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_minima.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] addr, logic [31:0] data);
        drain();
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= data[CFG_W-1:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (addr)
            CFG_WIDTH: begin
                width_reg = data[12:0];
                clear_positions();
            end
            CFG_HEIGHT: begin
                height_reg = data[12:0];
                clear_positions();
            end
            CFG_WINDOW: begin
                window_reg = data[6:0];
                clear_positions();
            end
            default: ;
        endcase
    endtask

    task automatic set_geometry(int unsigned w, int unsigned h, int unsigned win);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_WINDOW, win);
    endtask

    function automatic logic [31:0] random_pixel();
        case ($urandom_range(3))
            0: return $urandom_range(0, 15) - 8;
            1: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // Streams frames under the current geometry; a frame may be cut short.
    task automatic run_frames(int unsigned n_frames, int unsigned max_pixels);
        int unsigned w, hg, total;
        w = clamp_u(width_reg, 1, MAX_WIDTH);
        hg = clamp_u(height_reg, 1, MAX_HEIGHT);
        total = w * hg;
        for (int f = 0; f < n_frames; f++) begin
            for (int unsigned k = 0; k < total && k < max_pixels; k++) begin
                if ($urandom_range(99) < 8) send_item(OP_FLUSH, $urandom);
                if ($urandom_range(99) < 2) write_reg(CFG_SPARE, $urandom);
                send_item(OP_PIXEL, random_pixel());
            end
            if (total > max_pixels || $urandom_range(99) < 8) return;
            // Drain the frame; stray pixels here are dropped by the filter.
            while (frame_open())
                send_item(($urandom_range(99) < 15) ? OP_PIXEL : OP_FLUSH, random_pixel());
        end
    endtask

    dir_row_t directed [N_DIR] = '{
        '{ROW_ITEM, CFG_WIDTH,  32'd0,          OP_FLUSH, 0, 32'd0,          1'b0},
        '{ROW_CFG,  CFG_WIDTH,  32'd1,          OP_PIXEL, 0, 32'd0,          1'b0},
        '{ROW_CFG,  CFG_HEIGHT, 32'd1,          OP_PIXEL, 0, 32'd0,          1'b0},
        '{ROW_CFG,  CFG_WINDOW, 32'd2,          OP_PIXEL, 0, 32'd0,          1'b0},
        '{ROW_ITEM, CFG_WIDTH,  32'h8000_0000,  OP_PIXEL, 1, 32'h8000_0000,  1'b1},
        '{ROW_ITEM, CFG_WIDTH,  32'h7fff_ffff,  OP_PIXEL, 1, 32'h7fff_ffff,  1'b1},
        '{ROW_ITEM, CFG_WIDTH,  32'h0000_0000,  OP_PIXEL, 1, 32'h0000_0000,  1'b1},
        '{ROW_ITEM, CFG_WIDTH,  32'hffff_ffff,  OP_PIXEL, 1, 32'hffff_ffff,  1'b1},
        '{ROW_ITEM, CFG_WIDTH,  32'h1234_5678,  OP_FLUSH, 0, 32'd0,          1'b0},
        '{ROW_CFG,  CFG_WIDTH,  32'd0,          OP_PIXEL, 0, 32'd0,          1'b0},
        '{ROW_CFG,  CFG_HEIGHT, 32'd0,          OP_PIXEL, 0, 32'd0,          1'b0},
        '{ROW_CFG,  CFG_WINDOW, 32'd0,          OP_PIXEL, 0, 32'd0,          1'b0},
        '{ROW_ITEM, CFG_WIDTH,  32'h5555_5555,  OP_PIXEL, 1, 32'h5555_5555,  1'b1},
        '{ROW_ITEM, CFG_WIDTH,  32'haaaa_aaaa,  OP_PIXEL, 1, 32'haaaa_aaaa,  1'b1},
        '{ROW_CFG,  CFG_SPARE,  32'h1fff,       OP_PIXEL, 0, 32'd0,          1'b0},
        '{ROW_ITEM, CFG_WIDTH,  32'd5,          OP_PIXEL, 1, 32'd5,          1'b1},
        '{ROW_CFG,  CFG_WIDTH,  32'd3,          OP_PIXEL, 0, 32'd0,          1'b0},
        '{ROW_CFG,  CFG_HEIGHT, 32'd2,          OP_PIXEL, 0, 32'd0,          1'b0},
        '{ROW_CFG,  CFG_WINDOW, 32'd4,          OP_PIXEL, 0, 32'd0,          1'b0},
        '{ROW_ITEM, CFG_WIDTH,  32'd9,          OP_PIXEL, -1, 32'd0,         1'b0},
        '{ROW_ITEM, CFG_WIDTH,  32'hffff_fff0,  OP_PIXEL, -1, 32'd0,         1'b0},
        '{ROW_ITEM, CFG_WIDTH,  32'd3,          OP_PIXEL, -1, 32'd0,         1'b0},
        '{ROW_ITEM, CFG_WIDTH,  32'h7fff_ffff,  OP_PIXEL, -1, 32'd0,         1'b0},
        '{ROW_ITEM, CFG_WIDTH,  32'd2,          OP_PIXEL, -1, 32'd0,         1'b0},
        '{ROW_ITEM, CFG_WIDTH,  32'h8000_0000,  OP_PIXEL, -1, 32'd0,         1'b0}
    };

    // Result side stalls at random, except in the quiet stretch.
    always @(posedge aclk) begin
        m_tready <= no_idle || ($urandom_range(99) >= 31);
    end

    // Compare every minimum that leaves the filter with the oldest prediction.
    always @(posedge aclk) begin
        minimum_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_minima.size() == 0) begin
                failures++;
                if (mismatches + failures <= 10)
                    $display("unexpected minimum %h last %b", m_tdata, m_tlast);
            end else begin
                want = pending_minima.pop_front();
                if (m_tdata !== want.val || m_tlast !== want.last) begin
                    mismatches++;
                    if (mismatches + failures <= 10)
                        $display("minimum mismatch: expected %h last %b, got %h last %b",
                                 want.val, want.last, m_tdata, m_tlast);
                end
            end
        end
    end

    // Watchdog on cycles in which nothing moves.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !aresetn) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_MAX) begin
            $display("status: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        bit       got;
        minimum_t res;
        reset_filter_model();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part.
        foreach (directed[i]) begin
            if (directed[i].kind == ROW_CFG) begin
                write_reg(directed[i].addr, directed[i].data);
            end else begin
                send_request(directed[i].op, directed[i].data, got, res);
                if (directed[i].want_cnt >= 0 &&
                    (got != directed[i].want_cnt ||
                     (got && (res.val !== directed[i].want_val ||
                              res.last !== directed[i].want_last)))) begin
                    mismatches++;
                    if (mismatches + failures <= 10)
                        $display("directed row %0d: expected %0d %h %b, predicted %0d %h %b",
                                 i, directed[i].want_cnt, directed[i].want_val,
                                 directed[i].want_last, got, res.val, res.last);
                end
            end
        end
        while (frame_open()) send_item(OP_FLUSH, $urandom);

        // Geometry at the extremes; the two largest frames are cut short.
        set_geometry(13'h1fff, 1, 127);
        run_frames(1, 40);
        set_geometry(1, 13'h1fff, 127);
        run_frames(1, 70);
        set_geometry(2, 40, 64);
        run_frames(1, 80);
        set_geometry(12, 12, 64);
        run_frames(1, 200);

        // Random geometry, small frames; single frames near the end of the budget.
        while (items_sent < N_ITEMS) begin
            no_idle = (items_sent > 450 && items_sent < 580);
            set_geometry($urandom_range(1, 12), $urandom_range(1, 12), $urandom_range(0, 127));
            run_frames((items_sent + 300 < N_ITEMS) ? $urandom_range(1, 3) : 1, 200);
        end
        no_idle = 1'b0;

        drain();
        if (mismatches == 0 && failures == 0 && pending_minima.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== separable_sliding_minimum_2d.f =====
+incdir+hdl
hdl/ssm2d_pkg.sv
hdl/ssm2d_min_unit.sv
hdl/separable_sliding_minimum_2d.sv
dv/separable_sliding_minimum_2d_tb.sv
